@@ design/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg: shared types and codes of the frame ring consumer
// Request and result payloads, command queue entry, divider interface,
// action, status, result and register index codes.
// ----------------------------------------------------------------------------
package frc_pkg;

  // field widths
  localparam int FB_W       = 17;
  localparam int BB_W       = 21;
  localparam int FC_W       = 7;
  localparam int TGT_W      = 6;
  localparam int ST_W       = 3;
  localparam int RC_W       = 3;
  localparam int IDX_W      = 6;
  localparam int OFF_W      = 26;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // shared serial divider and offset multipliers
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = 5;
  localparam int MUL_W     = 33;

  // command queue
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;

  // actions
  localparam logic [ACT_W-1:0] ACT_SET     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CONSUME = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP     = 2'd3;

  // frame status
  localparam logic [ST_W-1:0] ST_UNUSED   = 3'd0;
  localparam logic [ST_W-1:0] ST_RESERVED = 3'd1;
  localparam logic [ST_W-1:0] ST_VALID    = 3'd2;
  localparam logic [ST_W-1:0] ST_COPY     = 3'd3;
  localparam logic [ST_W-1:0] ST_SKIP     = 3'd4;

  // result codes
  localparam logic [RC_W-1:0] RC_WRITTEN    = 3'd0;
  localparam logic [RC_W-1:0] RC_VALID_TAKE = 3'd1;
  localparam logic [RC_W-1:0] RC_COPY_TAKE  = 3'd2;
  localparam logic [RC_W-1:0] RC_FOUND      = 3'd3;
  localparam logic [RC_W-1:0] RC_NONE       = 3'd4;
  localparam logic [RC_W-1:0] RC_UNKNOWN    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;

  // register reset values
  localparam logic [FB_W-1:0] FRAME_BYTES_RST = 17'd2048;
  localparam logic [BB_W-1:0] BLOCK_BYTES_RST = 21'd4096;
  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [TGT_W-1:0] target_frame;
    logic [ST_W-1:0]  status_value;
  } in_req_t;

  typedef struct packed {
    logic [RC_W-1:0]  result_code;
    logic [IDX_W-1:0] frame_index;
    logic [OFF_W-1:0] frame_offset;
  } out_rsp_t;

  typedef struct packed {
    logic [ACT_W-1:0] op;
    logic [TGT_W-1:0] target;
    logic [ST_W-1:0]  sval;
  } cmd_t;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic             narrow;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ design/frame_ring_consumer_unit.sv @@
// ----------------------------------------------------------------------------
// frame_ring_consumer_unit: frame ring status table and head consumer
// Intake, command queue and execution engine of a ring of frames in blocks.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each set, consume
// or lookup request gives one result, shown for one cycle with out_valid,
// which the receiver cannot hold off. Results come in request order. After
// reset the status table is cleared, one entry a cycle, with busy high;
// frames per block are then worked out by the serial divider, or set to
// one when frame_bytes is zero, and again after every write of frame_bytes
// or block_bytes, with cfg_ready low while the divider runs. A consume or
// lookup request scans the frames, one a cycle from the table and at most
// the frame count; a set request or a scan hit then has the divider step
// through the index width W (6 by default) to split the index into block
// and slot for the offset, while a scan that ends without a hit gives its
// result without an offset. Two requests can wait in the queue, so intake
// stays open while the engine works.
module frame_ring_consumer_unit import frc_pkg::*; #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_req_t               in_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output out_rsp_t              out_data
);

  logic q_push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  cmd_t pop_cmd;
  logic q_empty;
  logic clearing;

  // intake
  frc_front u_front (
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // queue between intake and engine
  frc_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // engine
  frc_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ design/frc_front.sv @@
// ----------------------------------------------------------------------------
// frc_front: request intake
// Accepts requests, drops the no-op action and pushes the rest into the
// command queue.
// ----------------------------------------------------------------------------
module frc_front import frc_pkg::*; (
  input  logic    start,
  output logic    busy,
  input  in_req_t in_data,
  input  logic    q_full,
  input  logic    clearing,
  output logic    q_push,
  output cmd_t    q_cmd
);

  logic accept;

  // hold off while the table is being cleared or the queue has no room
  assign busy   = q_full || clearing;
  assign accept = start && !busy;

  // the no-op action is taken and then forgotten
  assign q_push = accept && (in_data.action != ACT_NOP);

  assign q_cmd.op     = in_data.action;
  assign q_cmd.target = in_data.target_frame;
  assign q_cmd.sval   = in_data.status_value;

endmodule

@@ design/frc_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// frc_cmd_queue: command queue
// Short FIFO between the intake and the execution engine.
// ----------------------------------------------------------------------------
module frc_cmd_queue import frc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                  ent_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_PTR_W:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + (CMDQ_PTR_W + 1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (CMDQ_PTR_W + 1)'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_cmd;
  end

endmodule

@@ design/frc_divider.sv @@
// ----------------------------------------------------------------------------
// frc_divider: serial restoring divider
// One quotient bit per cycle. Full mode runs DIV_W steps; narrow mode
// treats only the low NARROW_W dividend bits and runs NARROW_W steps.
// ----------------------------------------------------------------------------
module frc_divider import frc_pkg::*; #(
  parameter int NARROW_W = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 active_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W:0]       rem_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_W:0]       shifted;
  logic                 ge;

  // one restoring step
  assign shifted = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});

  assign rsp.done      = active_r && (cnt_r == '0);
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[DIV_W-1:0];

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      cnt_r    <= req.narrow ? DIV_CNT_W'(NARROW_W) : DIV_CNT_W'(DIV_W);
    end else if (active_r) begin
      if (cnt_r == '0) active_r <= 1'b0;
      else             cnt_r    <= cnt_r - DIV_CNT_W'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      if (req.narrow) quo_r <= req.dividend << (DIV_W - NARROW_W);
      else            quo_r <= req.dividend;
    end else if (active_r && (cnt_r != '0)) begin
      rem_r <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

endmodule

@@ design/frc_back.sv @@
// ----------------------------------------------------------------------------
// frc_back: execution engine
// Holds the registers, the status table and the head; runs set, consume
// and lookup commands and computes frame byte offsets.
// ----------------------------------------------------------------------------
module frc_back import frc_pkg::*; #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  cmd_t                  q_cmd,
  output logic                  clearing,
  output logic                  out_valid,
  output out_rsp_t              out_data
);

  localparam int HW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int IXW = (HW > IDX_W) ? HW : IDX_W;
  localparam int XW  = (HW > FC_W) ? HW + 1 : FC_W + 1;
  localparam logic [FC_W-1:0] CNT_CAP =
    (MAX_FRAMES < 127) ? FC_W'(MAX_FRAMES) : {FC_W{1'b1}};
  localparam logic [HW-1:0] LAST_ENTRY = HW'(MAX_FRAMES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FPB   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_OWAIT = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;

  logic [2:0]      state_r;
  logic [FB_W-1:0] frame_bytes_r;
  logic [BB_W-1:0] block_bytes_r;
  logic [FC_W-1:0] frame_count_r;
  logic [DIV_W-1:0] fpb_r;
  logic            fpb_dirty_r;
  logic [HW-1:0]   head_r;
  logic [HW-1:0]   start_r;
  logic [HW-1:0]   cur_r;
  logic [HW-1:0]   clr_r;
  logic [ACT_W-1:0] op_r;
  logic [ST_W-1:0] sval_r;
  logic [RC_W-1:0] code_r;
  logic [IXW-1:0]  rep_idx_r;
  logic [OFF_W-1:0] pa_r;
  logic [OFF_W-1:0] pb_r;
  logic            out_valid_r;
  out_rsp_t        out_data_r;
  logic [ST_W-1:0] rd_data_r;
  logic [ST_W-1:0] status_mem [MAX_FRAMES];

  logic [FC_W-1:0] cnt;
  logic [HW-1:0]   norm_head;
  logic [HW-1:0]   nxt_cur;
  logic [HW-1:0]   rd_addr;
  logic            mem_we;
  logic [HW-1:0]   mem_waddr;
  logic [ST_W-1:0] mem_wdata;
  logic            take_cmd;
  logic            set_cmd;
  logic            tgt_ok;
  logic            s_idle;
  logic            s_take;
  logic            scan_hit;
  logic [IXW-1:0]  off_idx;
  logic            fpb_start;
  logic            div_start;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic [MUL_W-1:0] pa;
  logic [MUL_W-1:0] pb;

  // frames in use, clamped to [1, MAX_FRAMES]
  always_comb begin
    if (frame_count_r == '0)          cnt = FC_W'(1);
    else if (frame_count_r > CNT_CAP) cnt = CNT_CAP;
    else                              cnt = frame_count_r;
  end

  // head wrap and scan step
  assign norm_head = (XW'(head_r) >= XW'(cnt)) ? '0 : head_r;
  assign nxt_cur   = ((XW'(cur_r) + XW'(1)) < XW'(cnt)) ? cur_r + HW'(1) : '0;

  // status classes of the frame under the scan
  assign s_idle = (rd_data_r == ST_UNUSED) || (rd_data_r == ST_RESERVED) ||
                  (rd_data_r == ST_SKIP);
  assign s_take = (rd_data_r == ST_VALID) || (rd_data_r == ST_COPY);

  // command dispatch
  assign take_cmd = (state_r == S_IDLE) && !fpb_dirty_r && !q_empty;
  assign set_cmd  = take_cmd && (q_cmd.op == ACT_SET);
  assign tgt_ok   = (int'(q_cmd.target) < MAX_FRAMES);
  assign q_pop    = take_cmd;
  assign scan_hit = (state_r == S_SCAN) &&
                    ((op_r == ACT_LOOKUP) ? (rd_data_r == sval_r) : s_take);

  // divider requests: frames per block, or index split for an offset
  assign fpb_start = (state_r == S_IDLE) && fpb_dirty_r && (frame_bytes_r != '0);
  assign off_idx   = set_cmd ? IXW'(q_cmd.target) : IXW'(cur_r);
  assign div_start = fpb_start || set_cmd || scan_hit;
  always_comb begin
    if (fpb_start) begin
      div_req.dividend = block_bytes_r;
      div_req.divisor  = DIV_W'(frame_bytes_r);
      div_req.narrow   = 1'b0;
    end else begin
      div_req.dividend = DIV_W'(off_idx);
      div_req.divisor  = fpb_r;
      div_req.narrow   = 1'b1;
    end
  end

  frc_divider #(
    .NARROW_W (IXW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // offset products: block index times block size, slot times frame size
  assign pa = MUL_W'(div_rsp.quotient[IXW-1:0]) * MUL_W'(block_bytes_r);
  assign pb = MUL_W'(div_rsp.remainder[IXW-1:0]) * MUL_W'(frame_bytes_r);

  // table read address and write port
  assign rd_addr = (state_r == S_IDLE) ? norm_head : nxt_cur;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = ST_UNUSED;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
    end else if (set_cmd && tgt_ok) begin
      mem_we    = 1'b1;
      mem_waddr = HW'(q_cmd.target);
      mem_wdata = q_cmd.sval;
    end else if ((state_r == S_SCAN) && (op_r == ACT_CONSUME) && s_take) begin
      mem_we    = 1'b1;
    end
  end

  // status table
  always_ff @(posedge clk) begin
    if (mem_we) status_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= status_mem[rd_addr];
  end

  // control and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      frame_bytes_r <= FRAME_BYTES_RST;
      block_bytes_r <= BLOCK_BYTES_RST;
      frame_count_r <= FRAME_COUNT_RST;
      fpb_dirty_r   <= 1'b1;
      head_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == LAST_ENTRY) state_r <= S_IDLE;
          else                     clr_r   <= clr_r + HW'(1);
        end
        S_IDLE: begin
          if (fpb_dirty_r) begin
            if (frame_bytes_r == '0) begin
              fpb_r       <= DIV_W'(1);
              fpb_dirty_r <= 1'b0;
            end else begin
              state_r <= S_FPB;
            end
          end else if (!q_empty) begin
            op_r   <= q_cmd.op;
            sval_r <= q_cmd.sval;
            if (q_cmd.op == ACT_SET) begin
              code_r    <= RC_WRITTEN;
              rep_idx_r <= off_idx;
              state_r   <= S_OWAIT;
            end else begin
              head_r  <= norm_head;
              start_r <= norm_head;
              cur_r   <= norm_head;
              state_r <= S_SCAN;
            end
          end
        end
        S_FPB: begin
          if (div_rsp.done) begin
            fpb_r       <= (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
            fpb_dirty_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            rep_idx_r <= off_idx;
            if (op_r == ACT_LOOKUP) begin
              code_r <= RC_FOUND;
              head_r <= cur_r;
            end else begin
              code_r <= (rd_data_r == ST_VALID) ? RC_VALID_TAKE : RC_COPY_TAKE;
              head_r <= nxt_cur;
            end
            state_r <= S_OWAIT;
          end else if ((op_r == ACT_CONSUME) && !s_idle) begin
            // unknown status stops the consume scan on that frame
            head_r                  <= cur_r;
            out_valid_r             <= 1'b1;
            out_data_r.result_code  <= RC_UNKNOWN;
            out_data_r.frame_index  <= IDX_W'(cur_r);
            out_data_r.frame_offset <= '0;
            state_r                 <= S_IDLE;
          end else if (nxt_cur == start_r) begin
            // wrapped around without a match: head stays at its start
            head_r                  <= start_r;
            out_valid_r             <= 1'b1;
            out_data_r.result_code  <= RC_NONE;
            out_data_r.frame_index  <= IDX_W'(start_r);
            out_data_r.frame_offset <= '0;
            state_r                 <= S_IDLE;
          end else begin
            cur_r <= nxt_cur;
          end
        end
        S_OWAIT: begin
          if (div_rsp.done) begin
            pa_r    <= pa[OFF_W-1:0];
            pb_r    <= pb[OFF_W-1:0];
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          out_valid_r             <= 1'b1;
          out_data_r.result_code  <= code_r;
          out_data_r.frame_index  <= rep_idx_r[IDX_W-1:0];
          out_data_r.frame_offset <= pa_r + pb_r;
          state_r                 <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // register writes; a size change recomputes frames per block
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_BYTES: begin
            frame_bytes_r <= cfg_data[FB_W-1:0];
            fpb_dirty_r   <= 1'b1;
          end
          CFG_BLOCK_BYTES: begin
            block_bytes_r <= cfg_data[BB_W-1:0];
            fpb_dirty_r   <= 1'b1;
          end
          CFG_FRAME_COUNT: frame_count_r <= cfg_data[FC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // no register write while the divider takes or holds the sizes
  assign cfg_ready = (state_r != S_FPB) && !fpb_start;
  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/tb_frame_ring_consumer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_ring_consumer_unit: self-checking bench of the frame ring consumer
// Runs a short directed table from reset, then several register settings
// (size extremes, bad sizes, frame count out of range, offset wrap) each with
// random set / consume / lookup traffic. Every result is checked field by
// field against a directed row's expectation or a bench model of table and head.
// ----------------------------------------------------------------------------
module tb_frame_ring_consumer_unit;
  import frc_pkg::*;

  localparam int RING_MAX     = 64;
  localparam int SETTLE_CYC   = 160;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 125;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_req_t               in_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  out_rsp_t              out_data;

  frame_ring_consumer_unit #(.MAX_FRAMES(RING_MAX)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // ring model state and register copies
  logic [ST_W-1:0] ring_tbl [0:RING_MAX-1];
  int unsigned     ring_head;
  logic [FB_W-1:0] reg_fb;
  logic [BB_W-1:0] reg_bb;
  logic [FC_W-1:0] reg_fc;

  // results still owed by the block, oldest first
  out_rsp_t pending_rsp [$];

  // directed table
  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;
  dir_row_t dir_rows [$];

  // typed expectation travels beside the request it belongs to
  bit       pin_on;
  out_rsp_t pin_rsp;

  bit gaps_on;
  int n_fail, n_req, n_rsp, n_phase, cycles;
  int code_cnt [0:7];

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_count();
    if (reg_fc == '0) return 1;
    if (int'(reg_fc) > RING_MAX) return RING_MAX;
    return 32'(reg_fc);
  endfunction

  function automatic int unsigned next_head(input int unsigned h, input int unsigned cnt);
    return (h + 1 < cnt) ? h + 1 : 0;
  endfunction

  function automatic bit status_is_idle(input logic [ST_W-1:0] s);
    return s == ST_UNUSED || s == ST_RESERVED || s == ST_SKIP;
  endfunction

  // block index times block size plus slot times frame size, 26-bit wrap
  function automatic logic [OFF_W-1:0] frame_offset_of(input int unsigned idx);
    longint unsigned fb = 64'(reg_fb);
    longint unsigned bb = 64'(reg_bb);
    longint unsigned fpb, off;
    fpb = 1;
    if (fb != 0 && bb / fb != 0) fpb = bb / fb;
    off = (64'(idx) / fpb) * bb + (64'(idx) % fpb) * fb;
    return off[OFF_W-1:0];
  endfunction

  // applies one request to the model; returns 0 when no result is due
  function automatic bit ring_predict(input in_req_t r, output out_rsp_t rsp);
    int unsigned cnt, first, k;
    logic [ST_W-1:0] s;
    rsp = '0;
    cnt = eff_count();
    if (r.action == ACT_NOP) return 1'b0;
    if (r.action == ACT_SET) begin
      ring_tbl[r.target_frame] = r.status_value;
      rsp.result_code  = RC_WRITTEN;
      rsp.frame_index  = r.target_frame;
      rsp.frame_offset = frame_offset_of(32'(r.target_frame));
      return 1'b1;
    end
    if (ring_head >= cnt) ring_head = 0;
    first = ring_head;

    // lookup: circular search, head parks on the match
    if (r.action == ACT_LOOKUP) begin
      for (k = 0; k < cnt; k++) begin
        if (ring_tbl[ring_head] == r.status_value) begin
          rsp.result_code  = RC_FOUND;
          rsp.frame_index  = IDX_W'(ring_head);
          rsp.frame_offset = frame_offset_of(ring_head);
          return 1'b1;
        end
        ring_head = next_head(ring_head, cnt);
        if (ring_head == first) break;
      end
      ring_head = first;
      rsp.result_code = RC_NONE;
      rsp.frame_index = IDX_W'(first);
      return 1'b1;
    end

    // consume: skip idle frames, stop on anything else
    s = ring_tbl[ring_head];
    if (status_is_idle(s)) begin
      ring_head = next_head(ring_head, cnt);
      while (ring_head != first && status_is_idle(ring_tbl[ring_head]))
        ring_head = next_head(ring_head, cnt);
      if (ring_head == first) begin
        rsp.result_code = RC_NONE;
        rsp.frame_index = IDX_W'(first);
        return 1'b1;
      end
      s = ring_tbl[ring_head];
    end
    if (s == ST_VALID || s == ST_COPY) begin
      rsp.result_code  = (s == ST_VALID) ? RC_VALID_TAKE : RC_COPY_TAKE;
      rsp.frame_index  = IDX_W'(ring_head);
      rsp.frame_offset = frame_offset_of(ring_head);
      ring_tbl[ring_head] = ST_UNUSED;
      ring_head = next_head(ring_head, cnt);
      return 1'b1;
    end
    rsp.result_code = RC_UNKNOWN;
    rsp.frame_index = IDX_W'(ring_head);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check results, log accepted requests and register writes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    out_rsp_t exp_r, pred;
    bit due;
    if (rst_n) begin
      if (out_valid) begin
        n_rsp++;
        if (pending_rsp.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: code %0d idx %0d off %0d",
                     out_data.result_code, out_data.frame_index, out_data.frame_offset);
        end else begin
          exp_r = pending_rsp.pop_front();
          code_cnt[exp_r.result_code]++;
          if (out_data.result_code != exp_r.result_code ||
              out_data.frame_index != exp_r.frame_index ||
              out_data.frame_offset != exp_r.frame_offset) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: exp code %0d idx %0d off %0d, got code %0d idx %0d off %0d",
                       exp_r.result_code, exp_r.frame_index, exp_r.frame_offset,
                       out_data.result_code, out_data.frame_index, out_data.frame_offset);
          end
        end
      end
      if (start && !busy) begin
        n_req++;
        due = ring_predict(in_data, pred);
        if (due) pending_rsp.push_back(pin_on ? pin_rsp : pred);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_BYTES: reg_fb = cfg_data[FB_W-1:0];
          CFG_BLOCK_BYTES: reg_bb = cfg_data[BB_W-1:0];
          CFG_FRAME_COUNT: reg_fc = cfg_data[FC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_req(input in_req_t r, input bit t_on, input out_rsp_t t_rsp);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    pin_on  <= t_on;
    pin_rsp <= t_rsp;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // all results in, then room for a trailing no-result request to finish
  task automatic settle_idle();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [ACT_W-1:0] act, input int unsigned tgt,
                         input logic [ST_W-1:0] st, input bit typed,
                         input logic [RC_W-1:0] rc, input int unsigned idx,
                         input int unsigned off);
    dir_row_t row;
    row.req.action       = act;
    row.req.target_frame = TGT_W'(tgt);
    row.req.status_value = st;
    row.typed            = typed;
    row.rsp.result_code  = rc;
    row.rsp.frame_index  = IDX_W'(idx);
    row.rsp.frame_offset = OFF_W'(off);
    dir_rows.push_back(row);
  endtask

  // mostly fill-then-drain traffic, with some lookups, junk status and no-ops
  function automatic in_req_t rand_req();
    in_req_t r;
    int p, q;
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    r.target_frame = ($urandom_range(0, 9) < 7) ? TGT_W'($urandom_range(0, eff_count() - 1))
                                               : TGT_W'($urandom_range(0, RING_MAX - 1));
    if (p < 45) begin
      r.action = ACT_SET;
      if (q < 40)      r.status_value = ST_VALID;
      else if (q < 70) r.status_value = ST_COPY;
      else if (q < 78) r.status_value = ST_UNUSED;
      else if (q < 86) r.status_value = ST_RESERVED;
      else if (q < 95) r.status_value = ST_SKIP;
      else             r.status_value = ST_W'($urandom_range(5, 7));
    end else if (p < 80) begin
      r.action = ACT_CONSUME;
      r.status_value = ST_W'($urandom_range(0, 7));
    end else if (p < 95) begin
      r.action = ACT_LOOKUP;
      r.status_value = (q < 80) ? ST_W'($urandom_range(0, 4)) : ST_W'($urandom_range(5, 7));
    end else begin
      r.action = ACT_NOP;
      r.status_value = ST_W'($urandom_range(0, 7));
    end
    return r;
  endfunction

  task automatic run_phase(input int unsigned fb, input int unsigned bb,
                           input int unsigned fc, input bit gaps);
    settle_idle();
    cfg_write(CFG_FRAME_BYTES, CFG_DATA_W'(fb));
    cfg_write(CFG_BLOCK_BYTES, CFG_DATA_W'(bb));
    cfg_write(CFG_FRAME_COUNT, CFG_DATA_W'(fc));
    gaps_on = gaps;
    repeat (PHASE_ITEMS) send_req(rand_req(), 1'b0, '0);
    start <= 1'b0;
    n_phase++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    int unsigned fb_r;
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_BYTES;
    cfg_data  = '0;
    pin_on    = 1'b0;
    pin_rsp   = '0;
    gaps_on   = 1'b1;
    cycles    = 0;
    for (int i = 0; i < RING_MAX; i++) ring_tbl[i] = ST_UNUSED;
    for (int i = 0; i < 8; i++) code_cnt[i] = 0;
    ring_head = 0;
    reg_fb    = FRAME_BYTES_RST;
    reg_bb    = BLOCK_BYTES_RST;
    reg_fc    = FRAME_COUNT_RST;

    // directed walk from reset values: two frames per block of 4096
    add_row(ACT_CONSUME, 0, ST_UNUSED, 1, RC_NONE, 0, 0);          // empty ring
    add_row(ACT_LOOKUP, 0, ST_VALID, 1, RC_NONE, 0, 0);
    add_row(ACT_SET, 0, ST_VALID, 1, RC_WRITTEN, 0, 0);
    add_row(ACT_SET, 63, ST_COPY, 1, RC_WRITTEN, 63, 129024);      // last frame
    add_row(ACT_SET, 5, 3'd7, 1, RC_WRITTEN, 5, 10240);            // junk status
    add_row(ACT_CONSUME, 0, ST_UNUSED, 1, RC_VALID_TAKE, 0, 0);
    add_row(ACT_CONSUME, 0, ST_UNUSED, 1, RC_UNKNOWN, 5, 0);       // scan hits junk
    add_row(ACT_CONSUME, 0, ST_UNUSED, 1, RC_UNKNOWN, 5, 0);       // junk at head
    add_row(ACT_SET, 5, ST_SKIP, 1, RC_WRITTEN, 5, 10240);
    add_row(ACT_LOOKUP, 0, ST_RESERVED, 1, RC_NONE, 5, 0);
    add_row(ACT_CONSUME, 0, ST_UNUSED, 1, RC_COPY_TAKE, 63, 129024); // head wraps
    add_row(ACT_SET, 10, ST_RESERVED, 1, RC_WRITTEN, 10, 20480);
    add_row(ACT_LOOKUP, 0, ST_RESERVED, 1, RC_FOUND, 10, 20480);
    add_row(ACT_NOP, 63, 3'd7, 0, RC_WRITTEN, 0, 0);               // no result
    add_row(ACT_SET, 1, 3'd6, 1, RC_WRITTEN, 1, 2048);
    add_row(ACT_LOOKUP, 0, 3'd6, 1, RC_FOUND, 1, 2048);            // wraps around
    add_row(ACT_LOOKUP, 0, 3'd5, 1, RC_NONE, 1, 0);
    add_row(ACT_CONSUME, 0, ST_UNUSED, 1, RC_UNKNOWN, 1, 0);
    add_row(ACT_SET, 1, ST_UNUSED, 1, RC_WRITTEN, 1, 2048);
    add_row(ACT_LOOKUP, 0, ST_UNUSED, 1, RC_FOUND, 1, 2048);
    add_row(ACT_SET, 62, ST_VALID, 0, RC_WRITTEN, 0, 0);
    add_row(ACT_CONSUME, 0, ST_UNUSED, 0, RC_WRITTEN, 0, 0);
    add_row(ACT_SET, 33, ST_COPY, 0, RC_WRITTEN, 0, 0);
    add_row(ACT_CONSUME, 0, ST_UNUSED, 0, RC_WRITTEN, 0, 0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    start <= 1'b0;
    n_phase++;

    // register settings: extremes, bad sizes, count out of range, offset wrap
    run_phase(16, 16, 1, 1);
    run_phase(65536, 1048576, 64, 1);
    run_phase(0, 4096, 0, 1);
    run_phase(0, 2097151, 64, 1);
    run_phase(3000, 2000, 40, 1);
    run_phase(131071, 2097151, 127, 1);
    run_phase(512, 8192, 48, 1);
    fb_r = $urandom_range(16, 4096);
    run_phase(fb_r, fb_r * $urandom_range(1, 8), $urandom_range(2, 64), 1);
    run_phase(2048, 4096, 64, 0);

    settle_idle();
    $display("ran %0d requests, %0d results over %0d register settings",
             n_req, n_rsp, n_phase);
    $display("codes: written %0d, valid %0d, copy %0d, found %0d, none %0d, unknown %0d",
             code_cnt[0], code_cnt[1], code_cnt[2], code_cnt[3], code_cnt[4], code_cnt[5]);
    if (n_fail == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", n_fail);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/frc_pkg.sv
design/frc_front.sv
design/frc_cmd_queue.sv
design/frc_divider.sv
design/frc_back.sv
design/frame_ring_consumer_unit.sv
sim/tb_frame_ring_consumer_unit.sv
